[rtl/mqsb_pkg.sv]
// Types and constants shared by the multi-queue shared buffer.
`default_nettype none
package mqsb_pkg;

  // Operation codes of the action field
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [1:0]         queue_id;
    logic signed [31:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] pop_value;
  } res_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage
`default_nettype wire

[rtl/mqsb_data_ram.sv]
// Single-port-write, registered-read data memory for queue entries.
`default_nettype none
module mqsb_data_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      wa,
  input  wire logic signed [31:0] wd,
  input  wire logic               re,
  input  wire logic [AW-1:0]      ra,
  output logic signed [31:0]      rd
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule
`default_nettype wire

[rtl/multi_queue_shared_buffer_top.sv]
// The result strobe (done) is registered from the execute state, which follows the accepted start transaction.
// Transactions are taken one at a time: start is not accepted while busy; busy is high for the one cycle in which
//   the link and data memory read data come back and the updates are written.
// Reset: all queues empty, free list is every entry in order; a fill count stands in
//   for the initial link chain, so no clearing pass is needed. Results cannot be stalled.
`default_nettype none
module multi_queue_shared_buffer_top #(
  parameter int ENTRIES = 64,
  parameter int QUEUES  = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire mqsb_pkg::cmd_t cmd,
  output logic               done,
  output mqsb_pkg::res_t     res
);

  localparam int AW  = $clog2(ENTRIES);
  localparam int LW  = $clog2(ENTRIES + 1);
  localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int QXW = (QW > 2) ? QW : 2;
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

  mqsb_pkg::state_t state, state_next;

  // Control and queue pointers
  logic [LW-1:0] free_head;
  logic [LW-1:0] fill;
  logic [LW-1:0] head [QUEUES];
  logic [AW-1:0] tail [QUEUES];

  // Command held for the execute cycle
  mqsb_pkg::cmd_t cmd_r;
  logic           q_ok_r;
  logic [QW-1:0]  idx_r;
  logic [LW-1:0]  slot_r;
  logic           fresh_r;

  // Link memory
  logic [LW-1:0] link_mem [ENTRIES];
  logic [LW-1:0] link_rd;
  logic          lk_we;
  logic [AW-1:0] lk_wa;
  logic [LW-1:0] lk_wd;

  logic signed [31:0] data_rd;
  logic               dt_we;

  logic           accept;
  logic           exec;
  logic [QXW-1:0] qx;
  logic [QW-1:0]  idx;
  logic           q_ok;
  logic [LW-1:0]  slot;

  logic          is_push;
  logic          op_ok;
  logic [LW-1:0] link_val;
  logic          q_empty;
  logic          last;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mqsb_pkg::ST_IDLE: if (start) state_next = mqsb_pkg::ST_EXEC;
      mqsb_pkg::ST_EXEC: state_next = mqsb_pkg::ST_IDLE;
      default:           state_next = mqsb_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    case (state)
      mqsb_pkg::ST_IDLE: busy = 1'b0;
      mqsb_pkg::ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default:           busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqsb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = start && !busy;

  // Decode the queue number of the incoming command
  assign qx   = QXW'(cmd.queue_id);
  assign idx  = qx[QW-1:0];
  assign q_ok = 32'(cmd.queue_id) < QUEUES;

  always_comb begin
    slot = NULL_LINK;
    if (q_ok) begin
      slot = (cmd.action == mqsb_pkg::ACT_PUSH) ? free_head : head[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd;
      q_ok_r  <= q_ok;
      idx_r   <= idx;
      slot_r  <= slot;
      fresh_r <= slot >= fill;
    end
  end

  // Link memory: read on accept, write back in the execute cycle
  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_wa] <= lk_wd;
    end
    if (accept) begin
      link_rd <= link_mem[slot[AW-1:0]];
    end
  end

  mqsb_data_ram #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_data_ram (
    .clk (clk),
    .we  (dt_we),
    .wa  (slot_r[AW-1:0]),
    .wd  (cmd_r.push_value),
    .re  (accept),
    .ra  (slot[AW-1:0]),
    .rd  (data_rd)
  );

  // Execute cycle: resolve link, decide the writes
  assign is_push  = cmd_r.action == mqsb_pkg::ACT_PUSH;
  assign op_ok    = exec && q_ok_r && (slot_r < NULL_LINK);
  // Entries at or above the fill count were never allocated and still chain in order
  assign link_val = fresh_r ? (slot_r + LW'(1)) : link_rd;
  assign q_empty  = head[idx_r] == NULL_LINK;
  // A popped head equal to the tail is the last entry of its queue
  assign last     = slot_r[AW-1:0] == tail[idx_r];

  always_comb begin
    lk_we = 1'b0;
    lk_wa = slot_r[AW-1:0];
    lk_wd = free_head;
    dt_we = 1'b0;
    if (op_ok) begin
      if (is_push) begin
        dt_we = 1'b1;
        if (!q_empty) begin
          lk_we = 1'b1;
          lk_wa = tail[idx_r];
          lk_wd = slot_r;
        end
      end else begin
        lk_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fill      <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head[i] <= NULL_LINK;
      end
    end else if (op_ok) begin
      if (is_push) begin
        free_head <= link_val;
        if (fresh_r) begin
          fill <= fill + LW'(1);
        end
        if (q_empty) begin
          head[idx_r] <= slot_r;
        end
      end else begin
        free_head   <= slot_r;
        head[idx_r] <= last ? NULL_LINK : link_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_ok && is_push) begin
      tail[idx_r] <= slot_r[AW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res.ok        <= op_ok;
      res.pop_value <= (op_ok && !is_push) ? data_rd : 32'sd0;
    end
  end

endmodule
`default_nettype wire

[sim/multi_queue_shared_buffer_top_tb.sv]
// Self-checking testbench for the multi-queue shared buffer with a free-list predictor.
`default_nettype none
module multi_queue_shared_buffer_top_tb;

  localparam int ENTRIES     = 64;
  localparam int QUEUES      = 4;
  localparam int NIL         = ENTRIES;
  localparam int NUM_ITEMS   = 1150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 10;

  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  mqsb_pkg::cmd_t cmd   = '0;
  logic           busy;
  logic           done;
  mqsb_pkg::res_t res;

  multi_queue_shared_buffer_top #(
    .ENTRIES(ENTRIES),
    .QUEUES (QUEUES)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .res  (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the buffer: word store, link chain, free list and per-queue ends
  logic signed [31:0] word_mem [ENTRIES];
  int                 next_link[ENTRIES];
  int                 free_top;
  int                 q_first  [QUEUES];
  int                 q_last   [QUEUES];

  mqsb_pkg::cmd_t pending_cmds[$];
  mqsb_pkg::res_t expected_results[$];

  int mismatches   = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int push_done    = 0;
  int push_full    = 0;
  int pop_done     = 0;
  int pop_empty    = 0;

  // burst/gap pacing of the sender
  int burst_left = 0;
  int gap_left   = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      word_mem[i]  = '0;
      next_link[i] = i + 1;
    end
    free_top = 0;
    for (int q = 0; q < QUEUES; q++) begin
      q_first[q] = NIL;
      q_last[q]  = 0;
    end
  end

  function automatic mqsb_pkg::res_t predict_queue_op(mqsb_pkg::cmd_t c);
    mqsb_pkg::res_t r;
    int             q;
    int             slot;
    r = '0;
    q = int'(c.queue_id);
    if (q < QUEUES) begin
      if (c.action == mqsb_pkg::ACT_PUSH) begin
        if (free_top != NIL) begin
          slot     = free_top;
          free_top = next_link[slot];
          if (q_first[q] == NIL) q_first[q] = slot;
          else next_link[q_last[q]] = slot;
          next_link[slot] = NIL;
          q_last[q]       = slot;
          word_mem[slot]  = c.push_value;
          r.ok            = 1'b1;
          push_done++;
        end else begin
          push_full++;
        end
      end else begin
        if (q_first[q] != NIL) begin
          slot            = q_first[q];
          q_first[q]      = next_link[slot];
          next_link[slot] = free_top;
          free_top        = slot;
          r.ok            = 1'b1;
          r.pop_value     = word_mem[slot];
          pop_done++;
        end else begin
          pop_empty++;
        end
      end
    end
    return r;
  endfunction

  task automatic add_cmd(logic act, int q, logic [31:0] value);
    mqsb_pkg::cmd_t c;
    c.action     = act;
    c.queue_id   = q[1:0];
    c.push_value = value;
    pending_cmds.push_back(c);
  endtask

  // Driver: hold an item until the block takes it, then pace the next by bursts and gaps
  always @(posedge clk) begin
    logic taken;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
    end else begin
      if (taken) expected_results.push_back(predict_queue_op(cmd));
      if (start && !taken) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        start <= 1'b1;
        cmd   <= pending_cmds.pop_front();
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation
  always @(posedge clk) begin
    mqsb_pkg::res_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result ok=%0b pop_value=%0d", res.ok, res.pop_value);
      end else begin
        want = expected_results.pop_front();
        if (res.ok !== want.ok || res.pop_value !== want.pop_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected ok=%0b pop_value=%0d, got ok=%0b pop_value=%0d",
                     results_seen, want.ok, want.pop_value, res.ok, res.pop_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("multi_queue_shared_buffer_top test failed");
      $finish;
    end
  end

  initial begin
    int   n;
    int   chunk;
    int   push_pct;
    int   focus_q;
    int   q;
    logic act;

    // underflow on every empty queue
    for (int i = 0; i < QUEUES; i++) add_cmd(mqsb_pkg::ACT_POP, i, $urandom);
    // extreme values and FIFO order per queue
    add_cmd(mqsb_pkg::ACT_PUSH, 0, 32'h7fff_ffff);
    add_cmd(mqsb_pkg::ACT_PUSH, 1, 32'h8000_0000);
    add_cmd(mqsb_pkg::ACT_PUSH, 2, 32'h0000_0000);
    add_cmd(mqsb_pkg::ACT_PUSH, 3, 32'hffff_ffff);
    add_cmd(mqsb_pkg::ACT_PUSH, 0, 32'h5555_5555);
    add_cmd(mqsb_pkg::ACT_PUSH, 3, 32'haaaa_aaaa);
    add_cmd(mqsb_pkg::ACT_POP, 0, $urandom);
    add_cmd(mqsb_pkg::ACT_POP, 0, $urandom);
    add_cmd(mqsb_pkg::ACT_POP, 1, $urandom);
    add_cmd(mqsb_pkg::ACT_POP, 2, $urandom);
    add_cmd(mqsb_pkg::ACT_POP, 3, $urandom);
    add_cmd(mqsb_pkg::ACT_POP, 3, $urandom);
    add_cmd(mqsb_pkg::ACT_POP, 1, $urandom);
    // interleave so freed entries are reused out of order
    add_cmd(mqsb_pkg::ACT_PUSH, 2, 32'd1);
    add_cmd(mqsb_pkg::ACT_PUSH, 2, 32'd2);
    add_cmd(mqsb_pkg::ACT_POP, 2, $urandom);
    add_cmd(mqsb_pkg::ACT_PUSH, 1, 32'd3);
    add_cmd(mqsb_pkg::ACT_POP, 2, $urandom);
    add_cmd(mqsb_pkg::ACT_POP, 1, $urandom);
    n = pending_cmds.size();

    // random phases: push-heavy to reach overflow, balanced, pop-heavy to drain
    chunk = 0;
    while (n < NUM_ITEMS) begin
      case (chunk % 3)
        0:       push_pct = 92;
        1:       push_pct = 50;
        default: push_pct = 12;
      endcase
      focus_q = ($urandom_range(0, 1) == 0) ? $urandom_range(0, QUEUES - 1) : -1;
      for (int k = $urandom_range(70, 120); k > 0 && n < NUM_ITEMS; k--) begin
        q = (focus_q >= 0 && $urandom_range(0, 3) != 0) ? focus_q
                                                       : $urandom_range(0, QUEUES - 1);
        act = ($urandom_range(1, 100) <= push_pct) ? mqsb_pkg::ACT_PUSH
                                                   : mqsb_pkg::ACT_POP;
        add_cmd(act, q, $urandom);
        n++;
      end
      chunk++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d transactions: %0d pushes stored, %0d pushes refused on a full buffer,",
             n, push_done, push_full);
    $display("  %0d pops returned data, %0d pops on an empty queue; %0d mismatches.",
             pop_done, pop_empty, mismatches);
    if (mismatches == 0) begin
      $display("multi_queue_shared_buffer_top test passed");
    end else begin
      $display("multi_queue_shared_buffer_top test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
